[hdl/thbt_pkg.sv]
// shared types and constants for the thermistor beta converter
// no dependencies
`timescale 1ns / 1ps

package thbt_pkg;

	localparam int ADC_W      = 12;
	localparam int LOGN_W     = 16;
	localparam int LOG_FRAC   = 28;
	localparam int TEMP_FRAC  = 24;
	localparam int LOG_W      = 32;
	localparam int DEN_W      = 48;
	localparam int Q_W        = 36;
	localparam int DIV_STEPS  = 79;
	localparam int DIV_PER_ST = 4;
	localparam int DIV_ST     = (DIV_STEPS + DIV_PER_ST - 1) / DIV_PER_ST;

	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [14:0] T0_HUND = 15'd29815;
	localparam logic [18:0] B100    = 19'd396500;
	localparam logic [26:0] DIV_NUM = 27'd118216475;

	localparam logic signed [14:0] OUT_MAX = 15'sd16383;
	localparam logic signed [14:0] OUT_MIN = 15'sh4000;

	typedef enum logic [1:0] {
		UNIT_C = 2'd0,
		UNIT_F = 2'd1,
		UNIT_K = 2'd2
	} unit_t;

	typedef struct packed {
		logic [ADC_W-1:0] reading;
	} sample_t;

	typedef struct packed {
		logic signed [14:0] temperature_tenths;
		logic               out_of_range;
	} result_t;

endpackage

[hdl/thbt_stream_if.sv]
// valid/ready channel carrying one payload struct
// payload type comes from thbt_pkg
`timescale 1ns / 1ps

interface thbt_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/thbt_log2_pipe.sv]
// log2 of an integer as unsigned Q28: normalize, then one squaring per stage
// uses thbt_pkg; load enables come from the top level valid chain
`timescale 1ns / 1ps

module thbt_log2_pipe
	import thbt_pkg::*;
(
	input  logic                clk,
	input  logic [LOG_FRAC:0]   ld,
	input  logic [LOGN_W-1:0]   n,
	output logic [LOG_W-1:0]    log_val
);

	localparam int E_W = $clog2(LOGN_W);

	logic [30:0]         f_s [LOG_FRAC+1];
	logic [E_W-1:0]      e_s [LOG_FRAC+1];
	logic [LOG_FRAC-1:0] b_s [LOG_FRAC+1];

	logic [E_W-1:0] e_n;
	logic [30:0]    f_n;

	always_comb begin
		e_n = '0;
		for (int i = 0; i < LOGN_W; i++) begin
			if (n[i]) e_n = E_W'(i);
		end
		f_n = 31'({15'd0, n} << (5'd30 - 5'(e_n)));
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			f_s[0] <= f_n;
			e_s[0] <= e_n;
			b_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
		logic [61:0] p;
		logic [31:0] g;
		assign p = 62'(f_s[k-1]) * 62'(f_s[k-1]);
		assign g = p[61:30];
		always_ff @(posedge clk) begin
			if (ld[k]) begin
				f_s[k] <= g[31] ? g[31:1] : g[30:0];
				e_s[k] <= e_s[k-1];
				b_s[k] <= {b_s[k-1][LOG_FRAC-2:0], g[31]};
			end
		end
	end

	assign log_val = LOG_W'({e_s[LOG_FRAC], b_s[LOG_FRAC]});

endmodule

[hdl/thermistor_beta_to_temperature_unit.sv]
// NTC thermistor converter: an ADC count in, a temperature in tenths out.
// Fully pipelined, 55 register stages: one request per clock enters while the
// output side keeps taking results. Most of the stages are the 28-stage log2
// squaring chains, which run side by side, and the 20-stage restoring divider
// (four quotient bits per stage). Each stage holds its item until the next
// frees up, so stalls collapse bubbles and lose nothing. Counts 0 and full
// scale flag out_of_range and report 0 K.
`timescale 1ns / 1ps

module thermistor_beta_to_temperature_unit
	import thbt_pkg::*;
#(
	parameter int ADC_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	thbt_stream_if.sink   sample,
	thbt_stream_if.source result
);

	localparam int NS     = 55;
	localparam int ST_L2  = 30;
	localparam int ST_LN  = 31;
	localparam int ST_DEN = 32;
	localparam int ST_DV0 = 33;
	localparam int ST_CA  = ST_DV0 + DIV_ST;
	localparam int ST_CB  = ST_CA + 1;
	localparam logic [LOGN_W:0] FS = (LOGN_W+1)'((1 << ADC_BITS) - 1);

	logic [1:0] unit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= UNIT_C;
		end else if (cfg_we) begin
			unit_q <= cfg_wdata;
		end
	end

	// valid chain with per-stage ready
	logic [NS-1:0] v_s;
	logic [NS:0]   rdy;
	logic [NS-1:0] ld;
	logic [NS-1:0] oor_s;

	assign rdy[NS] = result.ready;

	for (genvar i = 0; i < NS; i++) begin : g_vc
		logic prev_v;
		logic prev_o;
		if (i == 0) begin : g_first
			assign prev_v = sample.valid;
			assign prev_o = 1'b0;
		end else begin : g_rest
			assign prev_v = v_s[i-1];
			assign prev_o = oor_s[i-1];
		end
		assign rdy[i] = !v_s[i] || rdy[i+1];
		assign ld[i]  = rdy[i] && prev_v;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				v_s[i] <= prev_v;
			end
		end
		if (i > 0) begin : g_oor
			always_ff @(posedge clk) begin
				if (ld[i]) oor_s[i] <= prev_o;
			end
		end
	end

	assign sample.ready = rdy[0];

	// stage 0: range check and log2 ratio operands
	logic [LOGN_W-1:0] a_s0, b_s0;
	logic [LOGN_W:0]   cx;
	logic              oor_n;

	assign cx    = (LOGN_W+1)'(sample.data.reading);
	assign oor_n = (cx == '0) || (cx >= FS);

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			oor_s[0] <= oor_n;
			a_s0     <= oor_n ? LOGN_W'(1) : cx[LOGN_W-1:0];
			b_s0     <= oor_n ? LOGN_W'(1) : LOGN_W'(FS - cx);
		end
	end

	logic [LOG_W-1:0] la, lb;

	thbt_log2_pipe u_log_a (.clk(clk), .ld(ld[LOG_FRAC+1:1]), .n(a_s0), .log_val(la));
	thbt_log2_pipe u_log_b (.clk(clk), .ld(ld[LOG_FRAC+1:1]), .n(b_s0), .log_val(lb));

	// log ratio magnitude and sign
	logic [LOG_W-1:0] mag_s30;
	logic             neg_s30;
	logic signed [LOG_W:0] l2;

	assign l2 = $signed({1'b0, la}) - $signed({1'b0, lb});

	always_ff @(posedge clk) begin
		if (ld[ST_L2]) begin
			neg_s30 <= l2[LOG_W];
			mag_s30 <= l2[LOG_W] ? LOG_W'(-l2) : l2[LOG_W-1:0];
		end
	end

	// natural log, sign applied after truncation
	logic [61:0] lnp;
	logic signed [LOG_W:0] ln_s31;

	assign lnp = 62'(mag_s30) * 62'(LN2_Q30);

	always_ff @(posedge clk) begin
		if (ld[ST_LN]) begin
			ln_s31 <= neg_s30 ? -$signed({1'b0, lnp[61:30]}) : $signed({1'b0, lnp[61:30]});
		end
	end

	// denominator 100*B + 100*T0*ln r, Q28
	logic signed [49:0] den_full;
	logic signed [49:0] t0_ext;
	logic signed [49:0] ln_ext;
	logic [DEN_W-1:0]   den_s32;

	assign t0_ext   = 50'(T0_HUND);
	assign ln_ext   = 50'(ln_s31);
	assign den_full = $signed({3'd0, B100, 28'd0}) + t0_ext * ln_ext;

	always_ff @(posedge clk) begin
		if (ld[ST_DEN]) den_s32 <= den_full[DEN_W-1:0];
	end

	// restoring long division, a few quotient bits per stage
	logic [DEN_W-1:0] rem_s [DIV_ST+1];
	logic [DEN_W-1:0] dd_s  [DIV_ST+1];
	logic [Q_W-1:0]   q_s   [DIV_ST+1];

	assign rem_s[0] = '0;
	assign dd_s[0]  = den_s32;
	assign q_s[0]   = '0;

	for (genvar k = 0; k < DIV_ST; k++) begin : g_div
		logic [DEN_W:0]   r;
		logic [Q_W-1:0]   q;
		always_comb begin
			int idx;
			r = {1'b0, rem_s[k]};
			q = q_s[k];
			for (int j = 0; j < DIV_PER_ST; j++) begin
				idx = DIV_STEPS - 1 - DIV_PER_ST * k - j;
				if (idx >= 0) begin
					r = {r[DEN_W-1:0],
						(idx >= LOG_FRAC + TEMP_FRAC) ?
						DIV_NUM[5'(idx - LOG_FRAC - TEMP_FRAC)] : 1'b0};
					if (r >= {1'b0, dd_s[k]}) begin
						r = r - {1'b0, dd_s[k]};
						if (idx < Q_W) q[6'(idx)] = 1'b1;
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (ld[ST_DV0 + k]) begin
				rem_s[k+1] <= r[DEN_W-1:0];
				dd_s[k+1]  <= dd_s[k];
				q_s[k+1]   <= q;
			end
		end
	end

	// unit scaling
	logic [Q_W-1:0]     vk;
	logic [Q_W+3:0]     t10;
	logic [Q_W+7:0]     t180;
	logic [15:0]        kel_sa;
	logic signed [17:0] cel_sa;
	logic signed [21:0] fx_sa;

	assign vk   = oor_s[ST_CA-1] ? '0 : q_s[DIV_ST];
	assign t10  = (Q_W+4)'(vk) * (Q_W+4)'(10);
	assign t180 = (Q_W+8)'(vk) * (Q_W+8)'(180);

	always_ff @(posedge clk) begin
		if (ld[ST_CA]) begin
			kel_sa <= 16'((t10 + (Q_W+4)'(1 << (TEMP_FRAC-1))) >> TEMP_FRAC);
			cel_sa <= $signed(18'(t10 >> TEMP_FRAC)) - 18'sd2731;
			fx_sa  <= $signed(22'(t180 >> TEMP_FRAC)) - 22'sd45962;
		end
	end

	// floor divide by ten via reciprocal, after biasing positive
	logic [20:0]        fy;
	logic [44:0]        fyp;
	logic signed [21:0] fq;
	logic signed [21:0] tsel;
	result_t            res_sb;

	assign fy  = 21'(fx_sa + 22'sd50000);
	assign fyp = 45'(fy) * 45'd1677722;
	assign fq  = $signed(22'(fyp >> TEMP_FRAC)) - 22'sd5000;

	always_comb begin
		case (unit_q)
			UNIT_K:  tsel = $signed({6'd0, kel_sa});
			UNIT_F:  tsel = fq;
			default: tsel = 22'(cel_sa);
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld[ST_CB]) begin
			if (tsel > 22'(OUT_MAX))
				res_sb.temperature_tenths <= OUT_MAX;
			else if (tsel < 22'(OUT_MIN))
				res_sb.temperature_tenths <= OUT_MIN;
			else
				res_sb.temperature_tenths <= tsel[14:0];
			res_sb.out_of_range <= oor_s[ST_CB-1];
		end
	end

	assign result.valid = v_s[NS-1];
	assign result.data  = res_sb;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> v_s[0])
		else $error("accepted request did not enter the pipe");

	a_den_positive: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[ST_DEN] && !oor_s[ST_DEN] |-> (den_s32 != '0))
		else $error("divider denominator is zero");

	a_oor_kelvin: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.out_of_range && unit_q == UNIT_K
		|-> result.data.temperature_tenths == 15'sd0)
		else $error("out of range sample not reported as 0 K");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[ST_CA] && !rdy[ST_CA] |=> v_s[ST_CA] && $stable(kel_sa))
		else $error("stalled stage lost its item");

endmodule

[verif/tb.sv]
// testbench for thermistor_beta_to_temperature_unit: adc counts in, temperatures checked
// against an in-bench fixed-point beta-equation predictor, under random idling and backpressure
// depends on hdl/thbt_pkg.sv, hdl/thbt_stream_if.sv and the top level
`timescale 1ns / 1ps

module tb
	import thbt_pkg::*;
();

	localparam logic [1:0] UNIT_SPARE = 2'd3;
	localparam int FULL_SCALE = 4095;
	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_wdata = 2'd0;

	thbt_stream_if #(.payload_t(sample_t)) sample_ch ();
	thbt_stream_if #(.payload_t(result_t)) result_ch ();

	thermistor_beta_to_temperature_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.sample(sample_ch),
		.result(result_ch)
	);

	always #5 clk = ~clk;

	logic [1:0] unit_now = UNIT_C;
	result_t temp_expected[$];
	int errors = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit rx_hold = 1'b0;
	int stall_pattern = 0;

	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		result_ch.ready = 1'b0;
	end

	function automatic logic [63:0] log2_fixed(input logic [31:0] n);
		int e;
		int k;
		logic [63:0] f;
		logic [63:0] bits;
		e = 0;
		bits = 0;
		while (e < 31 && (n >> (e + 1)) != 0) e++;
		f = (e <= 30) ? (64'(n) << (30 - e)) : (64'(n) >> 1);
		for (k = 0; k < 28; k++) begin
			f = (f * f) >> 30;
			bits = bits << 1;
			if (f >= 64'h8000_0000) begin
				f = f >> 1;
				bits = bits | 64'd1;
			end
		end
		return (64'(e) << 28) | bits;
	endfunction

	function automatic logic [63:0] kelvin_fixed(input int c);
		longint l2;
		longint ln;
		longint den_s;
		logic [63:0] mag;
		logic [127:0] num;
		logic [127:0] quo;
		bit neg;
		l2 = longint'(log2_fixed(32'(c))) - longint'(log2_fixed(32'(FULL_SCALE - c)));
		neg = l2 < 0;
		mag = neg ? -l2 : l2;
		ln = longint'((mag * 64'(LN2_Q30)) >> 30);
		if (neg) ln = -ln;
		den_s = 64'd396500 * (64'd1 << 28) + 64'sd29815 * ln;
		if (den_s <= 0) return 64'd0;
		num = 128'(64'd3965 * 64'd29815) << 52;
		quo = num / 128'(den_s);
		return quo[63:0];
	endfunction

	function automatic result_t predict_temp(input int c, input logic [1:0] unit);
		result_t r;
		logic [63:0] v;
		longint t;
		longint a;
		longint d;
		bit oor;
		oor = (c == 0) || (c >= FULL_SCALE);
		v = oor ? 64'd0 : kelvin_fixed(c);
		case (unit)
			UNIT_K: t = longint'((10 * v + (64'd1 << 23)) >> 24);
			UNIT_F: begin
				d = longint'(10) << 24;
				a = longint'(180 * v) - (longint'(45962) << 24);
				t = (a >= 0) ? (a / d) : -((-a + d - 1) / d);
			end
			default: t = longint'((10 * v) >> 24) - 2731;
		endcase
		if (t > OUT_MAX) t = OUT_MAX;
		if (t < OUT_MIN) t = OUT_MIN;
		r.temperature_tenths = t[14:0];
		r.out_of_range = oor;
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[thermistor_beta_to_temperature_unit] ERROR");
			$finish;
		end
	end

	// result checker and stall pattern
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (temp_expected.size() == 0) begin
				report("unexpected request", got.temperature_tenths, 0);
			end else begin
				want = temp_expected.pop_front();
				if (got.temperature_tenths !== want.temperature_tenths)
					report("temperature_tenths", got.temperature_tenths,
						want.temperature_tenths);
				if (got.out_of_range !== want.out_of_range)
					report("out_of_range", int'(got.out_of_range),
						int'(want.out_of_range));
			end
		end
		stall_pattern <= stall_pattern + 1;
		if (rx_hold)
			result_ch.ready <= 1'b0;
		else if (stall_pattern[9:8] == 2'd0)
			result_ch.ready <= 1'b1;
		else
			result_ch.ready <= ($urandom_range(0, 3) != 0);
	end

	task automatic send_count(input logic [11:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		sample_ch.valid <= 1'b1;
		sample_ch.data <= c;
		do @(posedge clk); while (!sample_ch.ready);
		temp_expected.push_back(predict_temp(int'(c), unit_now));
	endtask

	task automatic set_unit(input logic [1:0] u);
		sample_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		wait (temp_expected.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= u;
		@(posedge clk);
		cfg_we <= 1'b0;
		unit_now = u;
	endtask

	task automatic test_extremes();
		send_count(12'd0);
		send_count(12'd4095);
		send_count(12'd1);
		send_count(12'd4094);
		send_count(12'd2047);
		send_count(12'd2048);
		send_count(12'hAAA);
		send_count(12'h555);
	endtask

	task automatic test_units();
		logic [1:0] u;
		for (int i = 0; i < 4; i++) begin
			u = (i == 0) ? UNIT_F : (i == 1) ? UNIT_K : (i == 2) ? UNIT_SPARE : UNIT_C;
			set_unit(u);
			send_count(12'd0);
			send_count(12'd4095);
			send_count(12'd1);
			send_count(12'd4094);
			send_count(12'd2048);
		end
	endtask

	task automatic test_random();
		logic [1:0] u;
		for (int i = 0; i < 420; i++) begin
			if (i % 70 == 0) begin
				u = 2'($urandom_range(0, 3));
				set_unit(u);
			end
			if ($urandom_range(0, 9) == 0)
				send_count(($urandom_range(0, 1) == 0) ? 12'd0 : 12'd4095);
			else
				send_count(12'($urandom_range(0, 4095)));
		end
	endtask

	// receiver holds off while requests keep coming, so the pipe fills and stalls
	task automatic test_backpressure();
		fork
			begin
				rx_hold = 1'b1;
				repeat (300) @(posedge clk);
				rx_hold = 1'b0;
			end
		join_none
		for (int i = 0; i < 100; i++) send_count(12'($urandom_range(0, 4095)));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_units();
		test_random();
		test_backpressure();
		sample_ch.valid <= 1'b0;
		wait (temp_expected.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[thermistor_beta_to_temperature_unit] OK");
		else
			$display("[thermistor_beta_to_temperature_unit] ERROR");
		$finish;
	end

endmodule

[files.f]
hdl/thbt_pkg.sv
hdl/thbt_stream_if.sv
hdl/thbt_log2_pipe.sv
hdl/thermistor_beta_to_temperature_unit.sv
verif/tb.sv
